// File: rtl/sssd_pkg.sv
// Package for the seven-segment scan driver: glyph table, state type and segment helper.
`timescale 1ns / 1ps
`default_nettype none

package sssd_pkg;

  // Width of the configured phase length and of the tick counter.
  localparam int unsigned TickW = 16;
  // Width of the displayed binary value.
  localparam int unsigned ValueW = 16;
  // Width of one raw segment pattern.
  localparam int unsigned PatW = 8;
  // Number of physical digit lines.
  localparam int unsigned LineCnt = 4;
  // Phase length after reset.
  localparam logic [TickW-1:0] TicksReset = 16'd10;

  // Divide by ten on a 16-bit value: q = (v * 0xCCCD) >> 19.
  localparam logic [ValueW-1:0] DivTenMul = 16'hCCCD;
  localparam int unsigned DivTenShift = 19;

  // Hex glyphs, bit6 = A down to bit0 = G.
  localparam logic [PatW-1:0] Glyphs [16] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70,
    8'h7F, 8'h7B, 8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47
  };

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } state_e;

  // Turns a pattern (bit6 = A .. bit0 = G) into active-low segment levels
  // (bit0 = A .. bit6 = G). The decimal point stays dark.
  function automatic logic [PatW-1:0] pat_to_seg(input logic [PatW-1:0] pat);
    logic [PatW-1:0] seg;
    seg = '1;
    for (int i = 0; i < 7; i++) begin
      seg[i] = ~pat[6-i];
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

// File: rtl/seven_segment_scan_driver_unit.sv
// Top level of the multiplexed seven-segment scan driver.
`timescale 1ns / 1ps
`default_nettype none

// Channel     | Direction | Handshake               | Payload
// ------------+-----------+-------------------------+-----------------------------------
// scan tick   | in        | in_valid_i / in_ready_o | display_value_i, pattern_digit0..3_i
// line levels | out       | out_valid_o/out_ready_i | digit_lines_o, segment_lines_o
// phase reg   | in        | cfg_we_i (no wait)      | cfg_wdata_i
//
// Every accepted tick produces exactly one transaction of line levels.
// A tick that changes nothing, starts a blanking phase or shows raw patterns
// goes straight to the done state, which loads the output register.
// A decimal drive phase first runs the shared divide-by-ten unit for digit
// index plus one steps before it reaches the done state.
// A new tick can be taken while the previous result still waits in the output
// register; the sequencer then holds its finished result until the slot frees.
// Reset (rst_ni low, asynchronous) sets the held digit levels all off, clears
// the held segment levels and loads a phase length of ten ticks.

module seven_segment_scan_driver_unit
  import sssd_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Phase length register.
  input  wire logic              cfg_we_i,
  input  wire logic [TickW-1:0]  cfg_wdata_i,
  // Scan tick transactions.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ValueW-1:0] display_value_i,
  input  wire logic [PatW-1:0]   pattern_digit0_i,
  input  wire logic [PatW-1:0]   pattern_digit1_i,
  input  wire logic [PatW-1:0]   pattern_digit2_i,
  input  wire logic [PatW-1:0]   pattern_digit3_i,
  // Line level transactions.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [LineCnt-1:0]     digit_lines_o,
  output logic [PatW-1:0]        segment_lines_o
);

  // The digit index needs at least one bit even for a single digit.
  localparam int unsigned IdxW  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  // The step counter must hold NUM_DIGITS itself.
  localparam int unsigned StepW = $clog2(NUM_DIGITS + 1);
  localparam logic [IdxW-1:0]  IdxLast = IdxW'(NUM_DIGITS - 1);
  localparam logic [StepW-1:0] StepOne = StepW'(1);

  state_e              state_q, state_d;
  logic [TickW-1:0]    ticks_per_phase_q;
  logic [TickW-1:0]    tick_count_q;
  logic                blank_done_q;
  logic [IdxW-1:0]     digit_index_q;
  logic [LineCnt-1:0]  digit_levels_q;
  logic [PatW-1:0]     segment_levels_q;

  // Shared divide-by-ten unit operands.
  logic [ValueW-1:0]   div_value_q;
  logic [StepW-1:0]    steps_q;

  // Output register.
  logic                out_valid_q;
  logic [LineCnt-1:0]  digit_lines_q;
  logic [PatW-1:0]     segment_lines_q;

  // Tick bookkeeping on acceptance.
  logic [TickW-1:0]    tick_next;
  logic                phase_change;
  logic [IdxW-1:0]     idx_eff;
  logic [IdxW-1:0]     idx_after;
  logic [LineCnt-1:0]  drive_levels;
  logic                raw_mode;
  logic [PatW-1:0]     raw_pat;
  logic                accept;
  logic                out_free;

  // Divider datapath.
  logic [2*ValueW-1:0] div_prod;
  logic [ValueW-1:0]   div_quot;
  logic [ValueW-1:0]   div_rem_full;
  logic [3:0]          div_rem;

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  assign tick_next    = tick_count_q + TickW'(1);
  assign phase_change = (tick_next >= ticks_per_phase_q);

  // The index never leaves its range, but an out-of-range value is folded
  // back to zero just as a wrap would.
  assign idx_eff   = (int'(digit_index_q) >= NUM_DIGITS) ? '0 : digit_index_q;
  assign idx_after = (idx_eff == IdxLast) ? '0 : idx_eff + IdxW'(1);

  assign raw_mode = |{pattern_digit0_i, pattern_digit1_i, pattern_digit2_i,
                      pattern_digit3_i};

  // Digit lines are mirrored: index 0, the ones place, drives line
  // NUM_DIGITS - 1. A mirrored line number of four or more pulls no line low.
  always_comb begin
    for (int k = 0; k < LineCnt; k++) begin
      drive_levels[k] = !((NUM_DIGITS - 1 - int'(idx_eff)) == k);
    end
  end

  // Raw pattern of the selected digit; a fifth digit has no pattern input.
  always_comb begin
    raw_pat = '0;
    if (int'(idx_eff) == 0) begin
      raw_pat = pattern_digit0_i;
    end else if (int'(idx_eff) == 1) begin
      raw_pat = pattern_digit1_i;
    end else if (int'(idx_eff) == 2) begin
      raw_pat = pattern_digit2_i;
    end else if (int'(idx_eff) == 3) begin
      raw_pat = pattern_digit3_i;
    end
  end

  // One divide-by-ten step: quotient by reciprocal multiply, remainder by
  // subtracting ten times the quotient.
  assign div_prod     = {{ValueW{1'b0}}, div_value_q} * {{ValueW{1'b0}}, DivTenMul};
  assign div_quot     = ValueW'(div_prod >> DivTenShift);
  assign div_rem_full = div_value_q - {div_quot[ValueW-4:0], 3'b000}
                                    - {div_quot[ValueW-2:0], 1'b0};
  assign div_rem      = div_rem_full[3:0];

  // Sequencer: idle waits for a tick, div runs the shared divider, done
  // hands the levels to the output register.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (phase_change && blank_done_q && !raw_mode) begin
            state_d = StDiv;
          end else begin
            state_d = StDone;
          end
        end
      end
      StDiv: begin
        if (steps_q == StepOne) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= StIdle;
      ticks_per_phase_q <= TicksReset;
      tick_count_q      <= '0;
      blank_done_q      <= 1'b0;
      digit_index_q     <= '0;
      digit_levels_q    <= '1;
      segment_levels_q  <= '0;
      out_valid_q       <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        ticks_per_phase_q <= cfg_wdata_i;
      end

      if (accept) begin
        if (!phase_change) begin
          tick_count_q <= tick_next;
        end else begin
          tick_count_q <= '0;
          blank_done_q <= !blank_done_q;
          if (!blank_done_q) begin
            // Blanking phase: all segments off, digit lines kept.
            segment_levels_q <= '1;
          end else begin
            digit_levels_q <= drive_levels;
            digit_index_q  <= idx_after;
            if (raw_mode) begin
              segment_levels_q <= pat_to_seg(raw_pat);
            end
          end
        end
      end

      // The last divider step leaves the wanted decimal digit as remainder.
      if (state_q == StDiv && steps_q == StepOne) begin
        segment_levels_q <= pat_to_seg(Glyphs[div_rem]);
      end

      // A new result replaces the one leaving in the same cycle.
      if (state_q == StDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider operands and output payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      div_value_q <= display_value_i;
      steps_q     <= StepW'(idx_eff) + StepOne;
    end else if (state_q == StDiv) begin
      div_value_q <= div_quot;
      steps_q     <= steps_q - StepOne;
    end
    if (state_q == StDone && out_free) begin
      digit_lines_q   <= digit_levels_q;
      segment_lines_q <= segment_levels_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign digit_lines_o   = digit_lines_q;
  assign segment_lines_o = segment_lines_q;

endmodule

`default_nettype wire
